>>> sv/mch_pkg.sv
// ----------------------------------------------------------------------------
// mch_pkg
// Shared types and constants for the max-channel histogram block.
// ----------------------------------------------------------------------------
package mch_pkg;

  localparam int BIN_IDX_W = 8;
  localparam int NUM_BINS  = 256;
  localparam int CHAN_W    = 8;
  localparam int OUT_CNT_W = 8;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_READ  = 1'b1
  } mch_func_t;

  typedef struct packed {
    mch_func_t             func;
    logic [CHAN_W-1:0]     red;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     blue;
    logic [BIN_IDX_W-1:0]  bin_select;
  } mch_in_t;

  typedef struct packed {
    logic [BIN_IDX_W-1:0]  bin_number;
    logic [OUT_CNT_W-1:0]  bin_count;
  } mch_out_t;

  // classified command handed from front to back
  typedef struct packed {
    mch_func_t             op;
    logic [BIN_IDX_W-1:0]  bin;
  } mch_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } mch_state_t;

endpackage

>>> sv/mch_ram.sv
// ----------------------------------------------------------------------------
// mch_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/mch_front.sv
// ----------------------------------------------------------------------------
// mch_front
// Accepts words, picks the bin (largest channel or selected bin) and queues
// the command for the back end.
// ----------------------------------------------------------------------------
module mch_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mch_pkg::mch_in_t  in_word,
  output logic              busy,
  output logic              cmd_valid,
  output mch_pkg::mch_cmd_t cmd,
  input  logic              pop
);
  import mch_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  mch_cmd_t         q_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  mch_cmd_t         cls;
  logic [CHAN_W-1:0] max_rg;
  logic [CHAN_W-1:0] max_rgb;

  // value channel = max of the three
  always_comb begin
    max_rg  = (in_word.green > in_word.red) ? in_word.green : in_word.red;
    max_rgb = (in_word.blue > max_rg) ? in_word.blue : max_rg;
    cls.op  = in_word.func;
    cls.bin = (in_word.func == FUNC_READ) ? in_word.bin_select : max_rgb;
  end

  assign busy      = (cnt_r == CNT_W'(QDEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> sv/mch_back.sv
// ----------------------------------------------------------------------------
// mch_back
// Read-modify-write of the bin store: increment on a pixel, report and clear
// on a read. Per-bin valid bits make unwritten bins read as zero.
// ----------------------------------------------------------------------------
module mch_back #(
  parameter int BIN_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  mch_pkg::mch_cmd_t cmd,
  output logic              pop,
  output logic              out_valid,
  output mch_pkg::mch_out_t out_word
);
  import mch_pkg::*;

  mch_state_t           state_r, state_nxt;
  mch_cmd_t             cur_r, cur_nxt;
  logic                 hit_r, hit_nxt;
  logic [NUM_BINS-1:0]  valid_r;
  logic                 out_valid_r, out_valid_nxt;
  mch_out_t             out_word_r, out_word_nxt;

  logic                 we;
  logic [BIN_WIDTH-1:0] wdata;
  logic [BIN_WIDTH-1:0] rdata;
  logic [BIN_WIDTH-1:0] count;

  mch_ram #(
    .WIDTH (BIN_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (we),
    .waddr (cur_r.bin),
    .wdata (wdata),
    .raddr (cmd.bin),
    .rdata (rdata)
  );

  assign count = hit_r ? rdata : '0;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    hit_nxt       = hit_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    pop           = 1'b0;
    we            = 1'b0;
    wdata         = '0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          pop       = 1'b1;
          cur_nxt   = cmd;
          hit_nxt   = valid_r[cmd.bin];
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        we        = 1'b1;
        state_nxt = ST_IDLE;
        if (cur_r.op == FUNC_READ) begin
          wdata                   = '0;
          out_valid_nxt           = 1'b1;
          out_word_nxt.bin_number = cur_r.bin;
          out_word_nxt.bin_count  = count[OUT_CNT_W-1:0];
        end else begin
          wdata = count + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (we) begin
        valid_r[cur_r.bin] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    hit_r      <= hit_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> sv/max_channel_histogram_core.sv
// A read word goes through the command queue, bin RAM read and output register
// to out_word with out_valid. Each command ends its read-then-write pass over
// the bin RAM before the next pops; busy is high when the 2-word queue fills.
// Reset: synchronous, active low; bin valid bits clear at once, so all bins
// read as zero right after reset with no clearing pass. Results cannot stall.
// ----------------------------------------------------------------------------
// max_channel_histogram_core
// 256-bin histogram of each pixel's largest channel, with read-and-clear.
// ----------------------------------------------------------------------------
module max_channel_histogram_core #(
  parameter int BIN_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mch_pkg::mch_in_t  in_word,
  output logic              out_valid,
  output mch_pkg::mch_out_t out_word
);
  import mch_pkg::*;

  mch_cmd_t cmd;
  logic     cmd_valid;
  logic     pop;

  mch_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop)
  );

  mch_back #(
    .BIN_WIDTH (BIN_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

>>> tb/sv/mch_histogram_checker.sv
// ----------------------------------------------------------------------------
// mch_histogram_checker
// Watches the command and result channels of the max-channel histogram core.
// Keeps a shadow copy of the bin store and checks each read word against it.
// ----------------------------------------------------------------------------
module mch_histogram_checker #(
  parameter int BIN_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  mch_pkg::mch_in_t  in_word,
  input  logic              out_valid,
  input  mch_pkg::mch_out_t out_word,
  output int                fail_count,
  output int                outstanding
);
  import mch_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic [BIN_WIDTH-1:0] shadow_bins [NUM_BINS];
  mch_out_t             pending_reads [$];
  int                   mismatches = 0;

  task automatic report_mismatch(string what, mch_out_t want, mch_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): exp bin %0d count %0d, got bin %0d count %0d",
               what, want.bin_number, want.bin_count, got.bin_number, got.bin_count);
    end
  endtask

  always @(posedge clk) begin : watch
    mch_out_t             want;
    logic [CHAN_W-1:0]    value;
    logic [BIN_IDX_W-1:0] sel;
    if (!rst_n) begin
      for (int k = 0; k < NUM_BINS; k++) shadow_bins[k] = '0;
      pending_reads.delete();
    end else begin
      // retire before accepting: a read word always belongs to an older command
      if (out_valid) begin
        if (pending_reads.size() == 0) begin
          report_mismatch("unexpected word", '0, out_word);
        end else begin
          want = pending_reads.pop_front();
          if (out_word.bin_number !== want.bin_number) begin
            report_mismatch("bin_number", want, out_word);
          end else if (out_word.bin_count !== want.bin_count) begin
            report_mismatch("bin_count", want, out_word);
          end
        end
      end
      if (start && !busy) begin
        if (in_word.func == FUNC_PIXEL) begin
          value = in_word.red;
          if (in_word.green > value) value = in_word.green;
          if (in_word.blue > value) value = in_word.blue;
          shadow_bins[value] = shadow_bins[value] + 1'b1;
        end else begin
          sel             = in_word.bin_select;
          want.bin_number = sel;
          want.bin_count  = shadow_bins[sel][OUT_CNT_W-1:0];
          shadow_bins[sel] = '0;
          pending_reads.insert(pending_reads.size(), want);
        end
      end
    end
    outstanding <= pending_reads.size();
    fail_count  <= mismatches;
  end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the max-channel histogram core: directed pixels and reads,
// random traffic with idle gaps, a counter wrap burst and a full-frame sweep.
// ----------------------------------------------------------------------------
module tb_top;
  import mch_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_W      = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 10;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  mch_in_t  in_word;
  logic     out_valid;
  mch_out_t out_word;
  int       fail_count;
  int       outstanding;
  int       cycles = 0;
  bit       no_idle = 0;

  max_channel_histogram_core #(.BIN_WIDTH(HIST_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  mch_histogram_checker #(.BIN_WIDTH(HIST_W)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_word    (out_word),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic mch_in_t pixel_word(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         logic [7:0] sel);
    mch_in_t w;
    w.func       = FUNC_PIXEL;
    w.red        = r;
    w.green      = g;
    w.blue       = b;
    w.bin_select = sel;
    return w;
  endfunction

  function automatic mch_in_t read_word(logic [7:0] sel, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b);
    mch_in_t w;
    w       = pixel_word(r, g, b, sel);
    w.func  = FUNC_READ;
    return w;
  endfunction

  // hold the word until the core takes it, then maybe leave a gap
  task automatic send_word(mch_in_t w);
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    if (!no_idle && $urandom_range(0, 99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // random word: small values half the time so bins fill up and get read back
  function automatic mch_in_t random_word();
    bit narrow;
    narrow = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 65) begin
      if (narrow) begin
        return pixel_word(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                          8'($urandom_range(0, 7)), 8'($urandom));
      end
      return pixel_word(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
    return read_word(narrow ? 8'($urandom_range(0, 7)) : 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // pixel whose largest channel is exactly peak
  function automatic mch_in_t peak_pixel(logic [7:0] peak);
    logic [7:0] ch [3];
    for (int k = 0; k < 3; k++) ch[k] = 8'($urandom_range(0, peak));
    ch[2'($urandom_range(0, 2))] = peak;
    return pixel_word(ch[0], ch[1], ch[2], 8'($urandom));
  endfunction

  initial begin
    logic [7:0] hot;
    start   <= 1'b0;
    in_word <= '0;
    rst_n   <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n   <= 1'b1;

    // directed, back to back to stress the read-modify-write path
    no_idle = 1;
    send_word(pixel_word(8'h00, 8'h00, 8'h00, 8'hFF));
    send_word(pixel_word(8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_word(pixel_word(8'hFF, 8'h00, 8'h00, 8'h12));
    send_word(pixel_word(8'h00, 8'hFF, 8'h00, 8'h34));
    send_word(pixel_word(8'h00, 8'h00, 8'hFF, 8'h56));
    send_word(pixel_word(8'd77, 8'd77, 8'd77, 8'h00));
    send_word(pixel_word(8'd77, 8'd77, 8'd12, 8'h00));
    send_word(pixel_word(8'd3, 8'd77, 8'd77, 8'h00));
    send_word(pixel_word(8'd128, 8'd127, 8'd1, 8'h00));
    send_word(read_word(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(read_word(8'd77, 8'h00, 8'h00, 8'h00));
    send_word(read_word(8'd77, 8'hA5, 8'h5A, 8'h3C));
    send_word(read_word(8'h00, 8'h00, 8'h00, 8'h00));
    send_word(read_word(8'd128, 8'h00, 8'h00, 8'h00));
    send_word(read_word(8'd200, 8'h00, 8'h00, 8'h00));
    send_word(pixel_word(8'hAA, 8'h55, 8'h0F, 8'h55));
    send_word(pixel_word(8'h55, 8'hAA, 8'hF0, 8'hAA));
    send_word(pixel_word(8'h0F, 8'hF0, 8'hAA, 8'h0F));
    send_word(read_word(8'hAA, 8'h00, 8'h00, 8'h00));
    send_word(read_word(8'hF0, 8'h00, 8'h00, 8'h00));
    send_word(pixel_word(8'h01, 8'h01, 8'h00, 8'h00));
    send_word(read_word(8'h01, 8'h01, 8'h01, 8'h01));
    wait_drained();

    // random traffic, a quiet stretch in the middle with no gaps
    for (int i = 0; i < 220; i++) begin
      no_idle = (i >= 80 && i < 160);
      if (i == 120) wait_drained();
      send_word(random_word());
    end
    no_idle = 0;
    wait_drained();

    // push one bin past its top so the count wraps
    hot = 8'($urandom_range(1, 254));
    for (int i = 0; i < 258; i++) send_word(peak_pixel(hot));
    send_word(read_word(hot, 8'($urandom), 8'($urandom), 8'($urandom)));

    // full sweep: read and clear every bin, then read the hot bin again to see it is empty
    for (int k = 0; k < NUM_BINS; k++) begin
      send_word(read_word(8'(k), 8'($urandom), 8'($urandom), 8'($urandom)));
    end
    send_word(read_word(hot, 8'h00, 8'h00, 8'h00));

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
